### hw/rtl/ndp_pkg.sv
// ----------------------------------------------------------------------------
// ndp_pkg
// Types and codes shared by the NDP message field extractor.
// ----------------------------------------------------------------------------
package ndp_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [4:0] RID_SUMMARY   = 5'd0;
  localparam logic [4:0] RID_RA_HDR    = 5'd1;
  localparam logic [4:0] RID_RETRANS   = 5'd2;
  localparam logic [4:0] RID_NA_FLAGS  = 5'd3;
  localparam logic [4:0] RID_TGT_HI    = 5'd4;
  localparam logic [4:0] RID_TGT_LO    = 5'd5;
  localparam logic [4:0] RID_RDST_HI   = 5'd6;
  localparam logic [4:0] RID_RDST_LO   = 5'd7;
  localparam logic [4:0] RID_RTGT_HI   = 5'd8;
  localparam logic [4:0] RID_RTGT_LO   = 5'd9;
  localparam logic [4:0] RID_SRC_LL    = 5'd10;
  localparam logic [4:0] RID_TGT_LL    = 5'd11;
  localparam logic [4:0] RID_PFX_LEN   = 5'd12;
  localparam logic [4:0] RID_PFX_LIFE  = 5'd13;
  localparam logic [4:0] RID_PFX_HI    = 5'd14;
  localparam logic [4:0] RID_PFX_LO    = 5'd15;
  localparam logic [4:0] RID_RED_HDR   = 5'd16;
  localparam logic [4:0] RID_MTU       = 5'd17;

  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_RS   = 3'd1;
  localparam logic [2:0] CLS_RA   = 3'd2;
  localparam logic [2:0] CLS_NS   = 3'd3;
  localparam logic [2:0] CLS_NA   = 3'd4;
  localparam logic [2:0] CLS_RDR  = 3'd5;

  localparam logic [7:0] OPT_SRC_LL = 8'd1;
  localparam logic [7:0] OPT_TGT_LL = 8'd2;
  localparam logic [7:0] OPT_PREFIX = 8'd3;
  localparam logic [7:0] OPT_RED    = 8'd4;
  localparam logic [7:0] OPT_MTU    = 8'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  icmp_type;
    logic        has_ipv6;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  record_id;
    logic [63:0] record_value;
    logic        last;
  } out_item_t;

endpackage

### hw/rtl/ndp_message_field_extractor.sv
// ----------------------------------------------------------------------------
// ndp_message_field_extractor
// Parses ICMPv6 neighbor discovery messages into tagged field records.
// ----------------------------------------------------------------------------
// Input channel in_*: start item, body bytes, end item of one message.
// Output channel out_*: tagged records, last set on the end summary.
// Each item is parsed in the cycle it is accepted; its records (up to four)
// land in a four-entry record buffer and leave one per cycle while the
// receiver is ready, starting the next cycle.
// An item that yields no record is taken every cycle while the buffer is
// free. An item that yields records holds the input until they leave: the
// buffer takes a new item only when empty or when its last record leaves
// in that cycle. When the receiver stalls, the buffer holds and in_ready
// stays low while any record is waiting.
// Reset closes any open message and empties the buffer.
// ----------------------------------------------------------------------------
module ndp_message_field_extractor #(
  parameter int unsigned MAX_BODY_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ndp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ndp_pkg::out_item_t  out_data
);

  localparam logic [7:0] OPT_SRC_LL_C = ndp_pkg::OPT_SRC_LL;
  localparam logic [7:0] OPT_TGT_LL_C = ndp_pkg::OPT_TGT_LL;
  localparam logic [7:0] OPT_PREFIX_C = ndp_pkg::OPT_PREFIX;
  localparam logic [7:0] OPT_RED_C    = ndp_pkg::OPT_RED;
  localparam logic [7:0] OPT_MTU_C    = ndp_pkg::OPT_MTU;

  logic [2:0]  cls_r, cls_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [5:0]  ostart_r, ostart_nxt;
  logic [15:0] ooff_r, ooff_nxt;
  logic [7:0]  otype_r, otype_nxt;
  logic [7:0]  olen_r, olen_nxt;
  logic        ostop_r, ostop_nxt;
  logic [63:0] cap_r [4];
  logic [63:0] cap_nxt [4];
  logic [1:0]  aflags_r, aflags_nxt;

  ndp_pkg::out_item_t buf_r [4];
  ndp_pkg::out_item_t buf_nxt [4];
  logic [2:0]  cnt_r, cnt_nxt;

  ndp_pkg::out_item_t rec [4];
  logic [2:0]  nrec;

  logic        in_acc, out_acc;
  logic        shift_en;
  logic [1:0]  shift_w;
  logic [5:0]  p;
  logic [5:0]  pm4;
  logic [11:0] opt_end;
  logic [7:0]  b;
  logic [63:0] w0;

  assign in_ready  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = buf_r[0];
  assign out_acc   = out_valid && out_ready;

  assign b       = in_data.data_byte;
  assign p       = pos_r[5:0];
  assign pm4     = p - 6'd4;
  assign opt_end = {1'b0, olen_r, 3'b000} - 12'd1;

  always_comb begin
    cls_nxt    = cls_r;
    pos_nxt    = pos_r;
    ostart_nxt = ostart_r;
    ooff_nxt   = ooff_r;
    otype_nxt  = otype_r;
    olen_nxt   = olen_r;
    ostop_nxt  = ostop_r;
    aflags_nxt = aflags_r;
    shift_en   = 1'b0;
    shift_w    = 2'd0;
    nrec       = 3'd0;
    for (int i = 0; i < 4; i++) begin
      rec[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    w0 = cap_r[0];

    case (in_data.kind)
      ndp_pkg::KIND_START: begin
        if (in_data.icmp_type >= 8'd133 && in_data.icmp_type <= 8'd137) begin
          cls_nxt = 3'(in_data.icmp_type - 8'd132);
        end else begin
          cls_nxt = ndp_pkg::CLS_NONE;
        end
        unique case (cls_nxt)
          ndp_pkg::CLS_RS:  ostart_nxt = 6'd4;
          ndp_pkg::CLS_RA:  ostart_nxt = 6'd12;
          ndp_pkg::CLS_NS,
          ndp_pkg::CLS_NA:  ostart_nxt = 6'd20;
          ndp_pkg::CLS_RDR: ostart_nxt = 6'd36;
          default:          ostart_nxt = 6'd0;
        endcase
        pos_nxt    = '0;
        ooff_nxt   = '0;
        otype_nxt  = '0;
        olen_nxt   = '0;
        ostop_nxt  = 1'b0;
        aflags_nxt = '0;
        if (cls_nxt != ndp_pkg::CLS_NONE && in_data.has_ipv6) begin
          aflags_nxt[0] = (in_data.source_high == 64'd0) && (in_data.source_low == 64'd0);
          aflags_nxt[1] = (in_data.dest_high == 64'hFF02_0000_0000_0000)
                       && (in_data.dest_low[63:24] == 40'h00_0000_01FF);
        end
      end
      ndp_pkg::KIND_BYTE: begin
        if (cls_r != ndp_pkg::CLS_NONE && 32'(pos_r) < MAX_BODY_BYTES) begin
          pos_nxt = pos_r + 16'd1;
          if (pos_r < 16'(ostart_r)) begin
            case (cls_r)
              ndp_pkg::CLS_RA: begin
                shift_en = 1'b1;
                shift_w  = p[4:3];
              end
              ndp_pkg::CLS_NS, ndp_pkg::CLS_NA: begin
                if (p < 6'd4) begin
                  shift_en = (cls_r == ndp_pkg::CLS_NA);
                  shift_w  = 2'd2;
                end else begin
                  shift_en = 1'b1;
                  shift_w  = pm4[4:3];
                end
              end
              ndp_pkg::CLS_RDR: begin
                shift_en = (p >= 6'd4);
                shift_w  = pm4[4:3];
              end
              default: shift_en = 1'b0;
            endcase
          end else if (!ostop_r) begin
            shift_en = (ooff_r < 16'd32);
            shift_w  = ooff_r[4:3];
            if (ooff_r == 16'd0) begin
              otype_nxt = b;
            end
            if (ooff_r == 16'd1) begin
              olen_nxt = b;
            end
            if (ooff_r == 16'd1 && b == 8'd0) begin
              ostop_nxt = 1'b1;
              ooff_nxt  = ooff_r + 16'd1;
            end else if (ooff_r != 16'd0 && olen_r != 8'd0
                         && ooff_r == 16'(opt_end)) begin
              ooff_nxt = '0;
            end else begin
              ooff_nxt = ooff_r + 16'd1;
            end
          end
        end
      end
      ndp_pkg::KIND_END: begin
        nrec = 3'd1;
        rec[0].record_id = ndp_pkg::RID_SUMMARY;
        rec[0].last      = 1'b1;
        if (cls_r != ndp_pkg::CLS_NONE) begin
          rec[0].record_value = {53'd0, aflags_r, 1'b1, 8'(8'd132 + 8'(cls_r))};
        end
        cls_nxt    = ndp_pkg::CLS_NONE;
        pos_nxt    = '0;
        ooff_nxt   = '0;
        ostop_nxt  = 1'b0;
        aflags_nxt = '0;
      end
      default: nrec = 3'd0;
    endcase

    if (shift_en) begin
      cap_nxt[shift_w] = {cap_r[shift_w][55:0], b};
    end
    w0 = cap_nxt[0];

    if (in_data.kind == ndp_pkg::KIND_BYTE && cls_r != ndp_pkg::CLS_NONE
        && 32'(pos_r) < MAX_BODY_BYTES) begin
      if (pos_r < 16'(ostart_r)) begin
        if (cls_r == ndp_pkg::CLS_RA && p == 6'd11) begin
          nrec   = 3'd2;
          rec[0] = '{ndp_pkg::RID_RA_HDR, cap_nxt[0], 1'b0};
          rec[1] = '{ndp_pkg::RID_RETRANS, {32'd0, cap_nxt[1][31:0]}, 1'b0};
        end else if (cls_r == ndp_pkg::CLS_NS && p == 6'd19) begin
          nrec   = 3'd2;
          rec[0] = '{ndp_pkg::RID_TGT_HI, cap_nxt[0], 1'b0};
          rec[1] = '{ndp_pkg::RID_TGT_LO, cap_nxt[1], 1'b0};
        end else if (cls_r == ndp_pkg::CLS_NA && p == 6'd19) begin
          nrec   = 3'd3;
          rec[0] = '{ndp_pkg::RID_NA_FLAGS,
                     {56'd0, cap_nxt[2][31:29], 5'd0}, 1'b0};
          rec[1] = '{ndp_pkg::RID_TGT_HI, cap_nxt[0], 1'b0};
          rec[2] = '{ndp_pkg::RID_TGT_LO, cap_nxt[1], 1'b0};
        end else if (cls_r == ndp_pkg::CLS_RDR && p == 6'd35) begin
          nrec   = 3'd4;
          rec[0] = '{ndp_pkg::RID_RDST_HI, cap_nxt[2], 1'b0};
          rec[1] = '{ndp_pkg::RID_RDST_LO, cap_nxt[3], 1'b0};
          rec[2] = '{ndp_pkg::RID_RTGT_HI, cap_nxt[0], 1'b0};
          rec[3] = '{ndp_pkg::RID_RTGT_LO, cap_nxt[1], 1'b0};
        end
      end else if (!ostop_r && ooff_r != 16'd0 && olen_r != 8'd0
                   && ooff_r == 16'(opt_end)
                   && !(ooff_r == 16'd1 && b == 8'd0)) begin
        case (otype_r)
          OPT_SRC_LL_C: begin
            nrec   = 3'd1;
            rec[0] = '{ndp_pkg::RID_SRC_LL, {16'd0, w0[47:0]}, 1'b0};
          end
          OPT_TGT_LL_C: begin
            nrec   = 3'd1;
            rec[0] = '{ndp_pkg::RID_TGT_LL, {16'd0, w0[47:0]}, 1'b0};
          end
          OPT_PREFIX_C: begin
            if (olen_r >= 8'd4) begin
              nrec   = 3'd4;
              rec[0] = '{ndp_pkg::RID_PFX_LEN,
                         {48'd0, w0[47:40], w0[39:38], 6'd0}, 1'b0};
              rec[1] = '{ndp_pkg::RID_PFX_LIFE,
                         {w0[31:0], cap_nxt[1][63:32]}, 1'b0};
              rec[2] = '{ndp_pkg::RID_PFX_HI, cap_nxt[2], 1'b0};
              rec[3] = '{ndp_pkg::RID_PFX_LO, cap_nxt[3], 1'b0};
            end
          end
          OPT_RED_C: begin
            nrec   = 3'd1;
            rec[0] = '{ndp_pkg::RID_RED_HDR, 64'd1, 1'b0};
          end
          OPT_MTU_C: begin
            nrec   = 3'd1;
            rec[0] = '{ndp_pkg::RID_MTU, {32'd0, w0[31:0]}, 1'b0};
          end
          default: nrec = 3'd0;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    cnt_nxt = cnt_r;
    if (out_acc) begin
      for (int i = 0; i < 3; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
    if (in_acc && nrec != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        buf_nxt[i] = rec[i];
      end
      cnt_nxt = nrec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r    <= ndp_pkg::CLS_NONE;
      pos_r    <= '0;
      ostart_r <= '0;
      ooff_r   <= '0;
      otype_r  <= '0;
      olen_r   <= '0;
      ostop_r  <= 1'b0;
      aflags_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        cls_r    <= cls_nxt;
        pos_r    <= pos_nxt;
        ostart_r <= ostart_nxt;
        ooff_r   <= ooff_nxt;
        otype_r  <= otype_nxt;
        olen_r   <= olen_nxt;
        ostop_r  <= ostop_nxt;
        aflags_r <= aflags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= cap_nxt[i];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("record count out of range");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("record changed while stalled");

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> cnt_r == 3'd0 || (cnt_r == 3'd1 && out_acc))
    else $error("item accepted with records pending");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind == ndp_pkg::KIND_END |=> out_valid && out_data.last)
    else $error("end item without summary record");

endmodule
